// ===== rtl/bhtl_pkg.sv =====
package bhtl_pkg;

  // LED duty resolution; the duty field is fixed at this width
  localparam int unsigned DUTY_BITS = 8;

  // Configuration register reset values
  localparam logic [7:0]  DEBOUNCE_TICKS_RST = 8'd30;
  localparam logic [15:0] HOLD_TICKS_RST     = 16'd500;
  localparam logic [7:0]  LED_STEP_TICKS_RST = 8'd10;
  localparam logic [31:0] REFRESH_TICKS_RST  = 32'd1000;

  // Hold counter ceiling
  localparam logic [15:0] HOLD_COUNT_MAX = 16'hFFFF;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DEBOUNCE_TICKS = 2'd0,
    REG_HOLD_TICKS     = 2'd1,
    REG_LED_STEP_TICKS = 2'd2,
    REG_REFRESH_TICKS  = 2'd3
  } reg_idx_e;

  // Controller phases as reported on the result beat
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_DEB     = 3'd1,
    PH_HOLD    = 3'd2,
    PH_HDEB    = 3'd3,
    PH_FETCH   = 3'd4,
    PH_REFRESH = 3'd5
  } phase_e;

  typedef struct packed {
    logic button_level;
    logic fetch_done;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] led_duty;
    logic                 fetch_request;
    logic [2:0]           phase;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] hold_ticks;
    logic [7:0]  led_step_ticks;
    logic [31:0] refresh_ticks;
  } cfg_t;

endpackage

// ===== rtl/bhtl_cfg.sv =====
module bhtl_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output bhtl_pkg::cfg_t     cfg_o
);

  bhtl_pkg::cfg_t cfg_q;
  logic           wr_en;

  // Always able to take a write beat
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  // Register file, truncate data to each register's width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= bhtl_pkg::DEBOUNCE_TICKS_RST;
      cfg_q.hold_ticks     <= bhtl_pkg::HOLD_TICKS_RST;
      cfg_q.led_step_ticks <= bhtl_pkg::LED_STEP_TICKS_RST;
      cfg_q.refresh_ticks  <= bhtl_pkg::REFRESH_TICKS_RST;
    end else if (wr_en) begin
      case (cfg_index_i)
        bhtl_pkg::REG_DEBOUNCE_TICKS: cfg_q.debounce_ticks <= cfg_data_i[7:0];
        bhtl_pkg::REG_HOLD_TICKS:     cfg_q.hold_ticks     <= cfg_data_i[15:0];
        bhtl_pkg::REG_LED_STEP_TICKS: cfg_q.led_step_ticks <= cfg_data_i[7:0];
        bhtl_pkg::REG_REFRESH_TICKS:  cfg_q.refresh_ticks  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/bhtl_core.sv =====
module bhtl_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  bhtl_pkg::in_item_t  item_i,
  input  bhtl_pkg::cfg_t      cfg_i,
  output bhtl_pkg::out_item_t res_o
);

  localparam logic [bhtl_pkg::DUTY_BITS-1:0] DutyMax = '1;

  bhtl_pkg::phase_e phase_q, phase_d;
  logic        prev_q, prev_d;
  logic        pend_q, pend_d;
  logic [7:0]  deb_q, deb_d;
  logic [15:0] hold_q, hold_d;
  logic [31:0] ref_q, ref_d;
  logic [bhtl_pkg::DUTY_BITS-1:0] bright_q, bright_d;
  logic        down_q, down_d;
  logic [7:0]  stepc_q, stepc_d;

  logic        lvl, edge_det, locked, locked_next, trigger;
  logic [15:0] hold_inc;
  logic [7:0]  deb_inc, step_inc;

  assign lvl         = item_i.button_level;
  assign edge_det    = lvl != prev_q;
  assign locked      = (phase_q == bhtl_pkg::PH_FETCH) || (phase_q == bhtl_pkg::PH_REFRESH);
  assign locked_next = (phase_d == bhtl_pkg::PH_FETCH) || (phase_d == bhtl_pkg::PH_REFRESH);
  assign hold_inc    = (hold_q != bhtl_pkg::HOLD_COUNT_MAX) ? hold_q + 16'd1 : hold_q;
  assign deb_inc     = deb_q + 8'd1;
  assign step_inc    = stepc_q + 8'd1;

  // Next state: phase sequencer, then breathing ramp
  always_comb begin
    phase_d  = phase_q;
    prev_d   = lvl;
    pend_d   = pend_q;
    deb_d    = deb_q;
    hold_d   = hold_q;
    ref_d    = ref_q;
    bright_d = bright_q;
    down_d   = down_q;
    stepc_d  = stepc_q;
    trigger  = 1'b0;

    case (phase_q)
      bhtl_pkg::PH_DEB: begin
        if (edge_det) pend_d = 1'b1;
        deb_d = deb_inc;
        if (deb_inc >= cfg_i.debounce_ticks) begin
          pend_d = 1'b0;
          if (!lvl) begin
            phase_d = bhtl_pkg::PH_HOLD;
            hold_d  = '0;
          end else begin
            phase_d = bhtl_pkg::PH_IDLE;
          end
        end
      end
      bhtl_pkg::PH_HOLD: begin
        hold_d = hold_inc;
        if (hold_inc >= cfg_i.hold_ticks) begin
          if (!lvl) begin
            phase_d = bhtl_pkg::PH_FETCH;
            pend_d  = 1'b0;
            trigger = 1'b1;
          end else begin
            phase_d = bhtl_pkg::PH_IDLE;
          end
        end else if (edge_det) begin
          phase_d = bhtl_pkg::PH_HDEB;
          deb_d   = '0;
        end
      end
      bhtl_pkg::PH_HDEB: begin
        hold_d = hold_inc;
        if (edge_det) pend_d = 1'b1;
        deb_d = deb_inc;
        if (deb_inc >= cfg_i.debounce_ticks) begin
          pend_d = 1'b0;
          if (lvl) begin
            phase_d = bhtl_pkg::PH_IDLE;
          end else if (hold_inc >= cfg_i.hold_ticks) begin
            phase_d = bhtl_pkg::PH_FETCH;
            trigger = 1'b1;
          end else begin
            phase_d = bhtl_pkg::PH_HOLD;
          end
        end
      end
      bhtl_pkg::PH_FETCH: begin
        if (edge_det) pend_d = 1'b1;
        if (item_i.fetch_done) begin
          ref_d = '0;
          if (cfg_i.refresh_ticks == '0) begin
            phase_d  = bhtl_pkg::PH_IDLE;
            pend_d   = 1'b0;
            bright_d = DutyMax;
            down_d   = 1'b1;
            stepc_d  = '0;
          end else begin
            phase_d = bhtl_pkg::PH_REFRESH;
          end
        end
      end
      bhtl_pkg::PH_REFRESH: begin
        if (edge_det) pend_d = 1'b1;
        ref_d = ref_q + 32'd1;
        if (ref_d >= cfg_i.refresh_ticks) begin
          phase_d  = bhtl_pkg::PH_IDLE;
          pend_d   = 1'b0;
          bright_d = DutyMax;
          down_d   = 1'b1;
          stepc_d  = '0;
        end
      end
      default: begin
        phase_d = bhtl_pkg::PH_IDLE;
        if (edge_det) begin
          phase_d = bhtl_pkg::PH_DEB;
          deb_d   = '0;
          pend_d  = 1'b0;
        end
      end
    endcase

    // Advance the breathing ramp outside the lockout
    if (!(locked || phase_d == bhtl_pkg::PH_FETCH || phase_d == bhtl_pkg::PH_REFRESH)) begin
      stepc_d = step_inc;
      if (step_inc >= cfg_i.led_step_ticks) begin
        stepc_d = '0;
        if (down_q) begin
          if (bright_q > '0) bright_d = bright_q - 1'b1;
          if (bright_q <= 1) down_d = 1'b0;
        end else begin
          if (bright_q < DutyMax) bright_d = bright_q + 1'b1;
          if (bright_q >= DutyMax - 1'b1) down_d = 1'b1;
        end
      end
    end
  end

  // Result fields for this tick
  always_comb begin
    res_o.led_duty      = (locked || locked_next) ? DutyMax : bright_q;
    res_o.fetch_request = trigger;
    res_o.phase         = phase_d;
  end

  // Commit state on each processed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= bhtl_pkg::PH_IDLE;
      prev_q   <= 1'b1;
      pend_q   <= 1'b0;
      deb_q    <= '0;
      hold_q   <= '0;
      ref_q    <= '0;
      bright_q <= '0;
      down_q   <= 1'b0;
      stepc_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      prev_q   <= prev_d;
      pend_q   <= pend_d;
      deb_q    <= deb_d;
      hold_q   <= hold_d;
      ref_q    <= ref_d;
      bright_q <= bright_d;
      down_q   <= down_d;
      stepc_q  <= stepc_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_req_enters_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.fetch_request |=> phase_q == bhtl_pkg::PH_FETCH)
    else $error("fetch request without entering fetch phase");

  a_lockout_full_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    locked |-> res_o.led_duty == DutyMax)
    else $error("duty not full scale during lockout");

  a_hold_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == bhtl_pkg::PH_HOLD && hold_q == bhtl_pkg::HOLD_COUNT_MAX
    |=> hold_q == bhtl_pkg::HOLD_COUNT_MAX)
    else $error("hold counter wrapped");

  a_resume_clears_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && locked && phase_d == bhtl_pkg::PH_IDLE
    |=> !pend_q && down_q && bright_q == DutyMax)
    else $error("resume did not restore ramp state");
`endif

endmodule

// ===== rtl/button_hold_trigger_breathing_led_top.sv =====
// Path: an accepted tick beat waits in the input register; its result is registered.
// Throughput: one tick per cycle while not stalled; input register, single-pass update, result register.
// The input side stalls only while a held input beat cannot move to a stalled result.
// Reset: asynchronous, active low; idle phase, released button, ramp at zero going up,
// registers 30, 500, 10 and 1000. No clearing pass.
module button_hold_trigger_breathing_led_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bhtl_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bhtl_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  bhtl_pkg::cfg_t      cfg;
  bhtl_pkg::in_item_t  in_q;
  bhtl_pkg::out_item_t res, out_q;
  logic                in_vld_q, out_vld_q;
  logic                adv, in_acc;

  // Result register can take a beat when empty or being drained
  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  bhtl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bhtl_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_vld_q && adv),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (adv && in_vld_q) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== sim/tb_button_hold_trigger_breathing_led_top.sv =====
module tb_button_hold_trigger_breathing_led_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_OFF_AT = 400;
  localparam int unsigned HOLD_OFF_CYCLES = 64;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    bhtl_pkg::in_item_t  tick;
    logic                typed;
    bhtl_pkg::out_item_t want;
    logic [3:0]          mask;
    bhtl_pkg::cfg_t      setting;
  } row_t;

  // Directed walk: reset state, debounce ending released, hold debounce into a
  // trigger with fetch done on the trigger tick, refresh exit, hold expiring on
  // a release, then a trigger with zero refresh time
  localparam int N_ROWS = 28;
  localparam row_t DIR_ROWS [N_ROWS] = '{
    '{ROW_TICK, 2'b10, 1'b1, {8'd0, 1'b0, bhtl_pkg::PH_IDLE}, 4'h0, '0},
    '{ROW_TICK, 2'b00, 1'b1, {8'd0, 1'b0, bhtl_pkg::PH_DEB}, 4'h0, '0},
    '{ROW_TICK, 2'b10, 1'b0, '0, 4'h0, '0},
    '{ROW_CFG,  2'b00, 1'b0, '0, 4'hF, {8'd2, 16'd3, 8'd1, 32'd1}},
    '{ROW_TICK, 2'b10, 1'b0, '0, 4'h0, '0},
    '{ROW_TICK, 2'b00, 1'b0, '0, 4'h0, '0},
    '{ROW_TICK, 2'b00, 1'b0, '0, 4'h0, '0},
    '{ROW_TICK, 2'b00, 1'b0, '0, 4'h0, '0},
    '{ROW_TICK, 2'b10, 1'b0, '0, 4'h0, '0},
    '{ROW_TICK, 2'b00, 1'b0, '0, 4'h0, '0},
    '{ROW_TICK, 2'b01, 1'b1, {8'd255, 1'b1, bhtl_pkg::PH_FETCH}, 4'h0, '0},
    '{ROW_TICK, 2'b00, 1'b1, {8'd255, 1'b0, bhtl_pkg::PH_FETCH}, 4'h0, '0},
    '{ROW_TICK, 2'b11, 1'b0, '0, 4'h0, '0},
    '{ROW_TICK, 2'b10, 1'b1, {8'd255, 1'b0, bhtl_pkg::PH_IDLE}, 4'h0, '0},
    '{ROW_TICK, 2'b00, 1'b0, '0, 4'h0, '0},
    '{ROW_TICK, 2'b00, 1'b0, '0, 4'h0, '0},
    '{ROW_TICK, 2'b00, 1'b0, '0, 4'h0, '0},
    '{ROW_TICK, 2'b00, 1'b0, '0, 4'h0, '0},
    '{ROW_TICK, 2'b00, 1'b0, '0, 4'h0, '0},
    '{ROW_TICK, 2'b10, 1'b0, '0, 4'h0, '0},
    '{ROW_CFG,  2'b00, 1'b0, '0, 4'b1000, {8'd0, 16'd0, 8'd0, 32'd0}},
    '{ROW_TICK, 2'b00, 1'b0, '0, 4'h0, '0},
    '{ROW_TICK, 2'b00, 1'b0, '0, 4'h0, '0},
    '{ROW_TICK, 2'b00, 1'b0, '0, 4'h0, '0},
    '{ROW_TICK, 2'b00, 1'b0, '0, 4'h0, '0},
    '{ROW_TICK, 2'b00, 1'b0, '0, 4'h0, '0},
    '{ROW_TICK, 2'b00, 1'b1, {8'd255, 1'b1, bhtl_pkg::PH_FETCH}, 4'h0, '0},
    '{ROW_TICK, 2'b01, 1'b1, {8'd255, 1'b0, bhtl_pkg::PH_IDLE}, 4'h0, '0}
  };

  logic                logic_dummy_unused_never;
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                tick_valid = 1'b0;
  logic                tick_stall;
  bhtl_pkg::in_item_t  tick_data = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  bhtl_pkg::out_item_t res_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [31:0]         cfg_data = '0;

  // Predictor state; pending edges are only ever discarded, so they are not kept
  bhtl_pkg::cfg_t   ctl_cfg = {bhtl_pkg::DEBOUNCE_TICKS_RST, bhtl_pkg::HOLD_TICKS_RST,
                               bhtl_pkg::LED_STEP_TICKS_RST, bhtl_pkg::REFRESH_TICKS_RST};
  bhtl_pkg::phase_e ctl_phase = bhtl_pkg::PH_IDLE;
  logic             ctl_level = 1'b1;
  logic [7:0]       deb_cnt = '0;
  logic [15:0]      hold_cnt = '0;
  logic [31:0]      refresh_cnt = '0;
  logic [bhtl_pkg::DUTY_BITS-1:0] bright = '0;
  logic             ramp_dn = 1'b0;
  logic [7:0]       step_cnt = '0;

  bhtl_pkg::out_item_t tick_results_q [$];
  bhtl_pkg::out_item_t want_beat;
  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned triggers_seen = 0;
  int unsigned settings_applied = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  int          burst_left = 0;

  button_hold_trigger_breathing_led_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (tick_valid),
    .in_stall_o  (tick_stall),
    .in_data_i   (tick_data),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_data_o  (res_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void bump_hold();
    if (hold_cnt != bhtl_pkg::HOLD_COUNT_MAX) hold_cnt = hold_cnt + 16'd1;
  endfunction

  function automatic void resume_breathing();
    ctl_phase = bhtl_pkg::PH_IDLE;
    bright = '1;
    ramp_dn = 1'b1;
    step_cnt = '0;
  endfunction

  // Advance the controller by one tick and return the beat it should emit
  function automatic bhtl_pkg::out_item_t advance_tick(bhtl_pkg::in_item_t it);
    logic                lvl;
    logic                changed;
    logic                locked;
    bhtl_pkg::out_item_t r;
    lvl = it.button_level;
    changed = (lvl != ctl_level);
    locked = (ctl_phase == bhtl_pkg::PH_FETCH) || (ctl_phase == bhtl_pkg::PH_REFRESH);
    ctl_level = lvl;
    r = '0;
    case (ctl_phase)
      bhtl_pkg::PH_DEB: begin
        deb_cnt = deb_cnt + 8'd1;
        if (deb_cnt >= ctl_cfg.debounce_ticks) begin
          if (!lvl) begin
            ctl_phase = bhtl_pkg::PH_HOLD;
            hold_cnt = '0;
          end else begin
            ctl_phase = bhtl_pkg::PH_IDLE;
          end
        end
      end
      bhtl_pkg::PH_HOLD: begin
        bump_hold();
        if (hold_cnt >= ctl_cfg.hold_ticks) begin
          if (!lvl) begin
            ctl_phase = bhtl_pkg::PH_FETCH;
            r.fetch_request = 1'b1;
          end else begin
            ctl_phase = bhtl_pkg::PH_IDLE;
          end
        end else if (changed) begin
          ctl_phase = bhtl_pkg::PH_HDEB;
          deb_cnt = '0;
        end
      end
      bhtl_pkg::PH_HDEB: begin
        bump_hold();
        deb_cnt = deb_cnt + 8'd1;
        if (deb_cnt >= ctl_cfg.debounce_ticks) begin
          if (lvl) begin
            ctl_phase = bhtl_pkg::PH_IDLE;
          end else if (hold_cnt >= ctl_cfg.hold_ticks) begin
            ctl_phase = bhtl_pkg::PH_FETCH;
            r.fetch_request = 1'b1;
          end else begin
            ctl_phase = bhtl_pkg::PH_HOLD;
          end
        end
      end
      bhtl_pkg::PH_FETCH: begin
        if (it.fetch_done) begin
          refresh_cnt = '0;
          if (ctl_cfg.refresh_ticks == 32'd0) resume_breathing();
          else ctl_phase = bhtl_pkg::PH_REFRESH;
        end
      end
      bhtl_pkg::PH_REFRESH: begin
        refresh_cnt = refresh_cnt + 32'd1;
        if (refresh_cnt >= ctl_cfg.refresh_ticks) resume_breathing();
      end
      default: begin
        ctl_phase = bhtl_pkg::PH_IDLE;
        if (changed) begin
          ctl_phase = bhtl_pkg::PH_DEB;
          deb_cnt = '0;
        end
      end
    endcase

    // Full scale during the lockout, otherwise the triangle wave
    if (locked || ctl_phase == bhtl_pkg::PH_FETCH || ctl_phase == bhtl_pkg::PH_REFRESH) begin
      r.led_duty = '1;
    end else begin
      r.led_duty = bright;
      step_cnt = step_cnt + 8'd1;
      if (step_cnt >= ctl_cfg.led_step_ticks) begin
        step_cnt = '0;
        if (ramp_dn) begin
          if (bright != '0) bright = bright - 1'b1;
          if (bright == '0) ramp_dn = 1'b0;
        end else begin
          if (bright != '1) bright = bright + 1'b1;
          if (bright == '1) ramp_dn = 1'b1;
        end
      end
    end
    r.phase = ctl_phase;
    return r;
  endfunction

  // Offer one tick beat, log its expectation on acceptance, then pace the sender
  task automatic drive_tick(bhtl_pkg::in_item_t it, logic typed, bhtl_pkg::out_item_t want);
    bhtl_pkg::out_item_t pred;
    int                  gap;
    tick_data <= it;
    tick_valid <= 1'b1;
    do @(posedge clk); while (tick_stall);
    pred = advance_tick(it);
    tick_results_q.push_back(typed ? want : pred);
    ticks_sent++;
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        tick_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Drain the block, then write the masked registers back to back
  task automatic apply_cfg(bhtl_pkg::cfg_t c, logic [3:0] mask);
    bhtl_pkg::reg_idx_e idx;
    logic [31:0]        wdata;
    tick_valid <= 1'b0;
    wait (tick_results_q.size() == 0);
    @(negedge clk);
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        idx = bhtl_pkg::reg_idx_e'(i);
        case (idx)
          bhtl_pkg::REG_DEBOUNCE_TICKS: begin
            wdata = 32'(c.debounce_ticks);
            ctl_cfg.debounce_ticks = c.debounce_ticks;
          end
          bhtl_pkg::REG_HOLD_TICKS: begin
            wdata = 32'(c.hold_ticks);
            ctl_cfg.hold_ticks = c.hold_ticks;
          end
          bhtl_pkg::REG_LED_STEP_TICKS: begin
            wdata = 32'(c.led_step_ticks);
            ctl_cfg.led_step_ticks = c.led_step_ticks;
          end
          default: begin
            wdata = c.refresh_ticks;
            ctl_cfg.refresh_ticks = c.refresh_ticks;
          end
        endcase
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= wdata;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
      end
    end
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // Presses sized to trigger unless the length cap cuts them short, short presses, glitches and plain noise
  task automatic run_random(int unsigned n_items);
    int unsigned        target;
    int                 kind;
    int                 span;
    int                 press_len;
    int                 rel_len;
    int                 bounce;
    int                 glitch_at;
    logic               noisy;
    bhtl_pkg::in_item_t it;
    target = ticks_sent + n_items;
    while (ticks_sent < target) begin
      span = 2 * int'(ctl_cfg.debounce_ticks) + int'(ctl_cfg.hold_ticks);
      kind = $urandom_range(0, 9);
      noisy = 1'b0;
      bounce = $urandom_range(0, 3);
      glitch_at = -1;
      if (kind < 6) begin
        press_len = span + $urandom_range(1, 8);
        if (press_len > 300) press_len = 300;
        rel_len = $urandom_range(1, 8);
        if ($urandom_range(0, 3) == 0) glitch_at = $urandom_range(1, press_len - 1);
      end else if (kind < 8) begin
        press_len = $urandom_range(1, (span > 300) ? 300 : span);
        rel_len = $urandom_range(1, 4);
      end else begin
        noisy = 1'b1;
        press_len = $urandom_range(1, 10);
        rel_len = 0;
      end
      for (int t = 0; t < press_len + rel_len; t++) begin
        if (noisy || t < bounce) it.button_level = 1'($urandom_range(0, 1));
        else if (t >= press_len || t == glitch_at) it.button_level = 1'b1;
        else it.button_level = 1'b0;
        it.fetch_done = ($urandom_range(0, 5) == 0);
        drive_tick(it, 1'b0, '0);
      end
    end
  endtask

  // Stimulus
  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_CFG) apply_cfg(DIR_ROWS[i].setting, DIR_ROWS[i].mask);
      else drive_tick(DIR_ROWS[i].tick, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    apply_cfg({8'd1, 16'd1, 8'd1, 32'd0}, 4'hF);
    run_random(80);
    apply_cfg({8'd0, 16'd2, 8'd0, 32'd1}, 4'hF);
    run_random(80);
    apply_cfg({8'd255, 16'hFFFF, 8'd255, 32'd100}, 4'hF);
    run_random(300);
    // Refresh at full range: a trigger here stays locked out until the next setting
    apply_cfg({8'd1, 16'd5, 8'd3, 32'hFFFF_FFFF}, 4'hF);
    run_random(80);
    repeat (6) begin
      apply_cfg({8'($urandom_range(1, 6)), 16'($urandom_range(1, 40)),
                 8'($urandom_range(1, 4)), 32'($urandom_range(0, 30))}, 4'hF);
      run_random(80);
    end

    tick_valid <= 1'b0;
    wait (tick_results_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d ticks over %0d register settings, %0d result beats checked",
             ticks_sent, settings_applied, results_seen);
    $display("summary: %0d confirmed long presses, %0d mismatches",
             triggers_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver stall pattern, with one long hold-off so the input backs up
  initial begin
    int   mode = 0;
    int   left = 0;
    logic held_off = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held_off && ticks_sent >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        res_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        if (left <= 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(5, 60);
        end
        left--;
        case (mode)
          0: res_stall <= 1'b0;
          1: res_stall <= ($urandom_range(0, 3) == 0);
          2: res_stall <= ($urandom_range(0, 9) < 7);
          default: res_stall <= ~res_stall;
        endcase
      end
    end
  end

  // Check each accepted result beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && res_valid && !res_stall) begin
      if (tick_results_q.size() == 0) begin
        $error("result beat with no tick waiting: duty %0d req %0d phase %0d",
               res_data.led_duty, res_data.fetch_request, res_data.phase);
        mismatches++;
      end else begin
        want_beat = tick_results_q.pop_front();
        results_seen++;
        if (res_data.fetch_request) triggers_seen++;
        if (res_data.led_duty !== want_beat.led_duty) begin
          $error("led_duty: expected %0d, got %0d", want_beat.led_duty, res_data.led_duty);
          mismatches++;
        end
        if (res_data.fetch_request !== want_beat.fetch_request) begin
          $error("fetch_request: expected %0d, got %0d",
                 want_beat.fetch_request, res_data.fetch_request);
          mismatches++;
        end
        if (res_data.phase !== want_beat.phase) begin
          $error("phase: expected %0d, got %0d", want_beat.phase, res_data.phase);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/bhtl_pkg.sv
rtl/bhtl_cfg.sv
rtl/bhtl_core.sv
rtl/button_hold_trigger_breathing_led_top.sv
sim/tb_button_hold_trigger_breathing_led_top.sv
